FILE: design/btre_pkg.sv
// shared types and constants of the band threshold run encoder
package btre_pkg;

   localparam int PIXEL_BITS     = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 13;
   localparam int RUN_POS_BITS   = 12;
   localparam int RUN_END_BITS   = 13;

   localparam int DEFAULT_MAX_WIDTH  = 4096;
   localparam int DEFAULT_MAX_HEIGHT = 4096;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOW_GRAY  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HIGH_GRAY = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROW_WIDTH = 2'd2;

   // reset values
   localparam logic [PIXEL_BITS-1:0]    LOW_GRAY_RESET  = 8'd0;
   localparam logic [PIXEL_BITS-1:0]    HIGH_GRAY_RESET = 8'd255;
   localparam logic [CSR_DATA_BITS-1:0] ROW_WIDTH_RESET = 13'd640;

   typedef struct packed {
      logic [PIXEL_BITS-1:0]    low_gray;
      logic [PIXEL_BITS-1:0]    high_gray;
      logic [CSR_DATA_BITS-1:0] row_width;
   } cfg_type;

   typedef struct packed {
      logic                     hit;
      logic [RUN_POS_BITS-1:0]  run_row;
      logic [RUN_POS_BITS-1:0]  run_begin;
      logic [RUN_END_BITS-1:0]  run_end;
   } run_type;

endpackage

FILE: design/btre_csr.sv
// configuration registers of the band threshold run encoder
module btre_csr
   import btre_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [CSR_INDEX_BITS-1:0] wr_index,
   input  logic [CSR_DATA_BITS-1:0]  wr_data,
   output cfg_type                   cfg
);

   logic [PIXEL_BITS-1:0]    low_gray_ff,  low_gray_in;
   logic [PIXEL_BITS-1:0]    high_gray_ff, high_gray_in;
   logic [CSR_DATA_BITS-1:0] row_width_ff, row_width_in;

   always_comb begin
      low_gray_in  = low_gray_ff;
      high_gray_in = high_gray_ff;
      row_width_in = row_width_ff;
      if (wr_en) begin
         case (wr_index)
            REG_LOW_GRAY:  low_gray_in  = wr_data[PIXEL_BITS-1:0];
            REG_HIGH_GRAY: high_gray_in = wr_data[PIXEL_BITS-1:0];
            REG_ROW_WIDTH: row_width_in = wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_gray_ff  <= LOW_GRAY_RESET;
         high_gray_ff <= HIGH_GRAY_RESET;
         row_width_ff <= ROW_WIDTH_RESET;
      end else begin
         low_gray_ff  <= low_gray_in;
         high_gray_ff <= high_gray_in;
         row_width_ff <= row_width_in;
      end
   end

   assign cfg.low_gray  = low_gray_ff;
   assign cfg.high_gray = high_gray_ff;
   assign cfg.row_width = row_width_ff;

endmodule

FILE: design/btre_scan.sv
// scan state and run detection, one pixel per step
module btre_scan
   import btre_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  step,
   input  logic [PIXEL_BITS-1:0] pixel,
   input  logic                  frame_start,
   output run_type               run
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int ROW_BITS = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CMP_BITS = (COL_BITS + 1 > CSR_DATA_BITS + 1) ? COL_BITS + 1
                                                                : CSR_DATA_BITS + 1;
   localparam logic [CMP_BITS-1:0] WIDTH_LIMIT = CMP_BITS'(MAX_WIDTH);
   localparam logic [ROW_BITS-1:0] ROW_LIMIT   = ROW_BITS'(MAX_HEIGHT - 1);

   logic                prev_fg_ff,   prev_fg_in;
   logic [COL_BITS-1:0] column_ff,    column_in;
   logic [ROW_BITS-1:0] row_ff,       row_in;
   logic [COL_BITS-1:0] run_start_ff, run_start_in;

   logic                prev_fg, fg, last, closes;
   logic [COL_BITS-1:0] col, row_start_col, start_col;
   logic [ROW_BITS-1:0] row;
   logic [CMP_BITS-1:0] width_raw, width_eff, col_next, end_col;

   always_comb begin
      // frame start clears position and drops an open run
      prev_fg       = frame_start ? 1'b0 : prev_fg_ff;
      col           = frame_start ? '0 : column_ff;
      row           = frame_start ? '0 : row_ff;
      row_start_col = frame_start ? '0 : run_start_ff;

      width_raw = CMP_BITS'(cfg.row_width);
      width_eff = width_raw;
      if (width_raw == '0)
         width_eff = CMP_BITS'(1);
      if (width_eff > WIDTH_LIMIT)
         width_eff = WIDTH_LIMIT;

      fg       = (pixel >= cfg.low_gray) && (pixel <= cfg.high_gray);
      col_next = CMP_BITS'(col) + CMP_BITS'(1);
      last     = col_next >= width_eff;

      start_col = (fg && !prev_fg) ? col : row_start_col;
      closes    = !fg && prev_fg;
      end_col   = closes ? CMP_BITS'(col) : col_next;

      run.hit       = closes || (fg && last);
      run.run_row   = RUN_POS_BITS'(32'(row));
      run.run_begin = RUN_POS_BITS'(32'(start_col));
      run.run_end   = RUN_END_BITS'(32'(end_col));

      run_start_in = start_col;
      if (last) begin
         prev_fg_in = 1'b0;
         column_in  = '0;
         row_in     = (row < ROW_LIMIT) ? row + ROW_BITS'(1) : row;
      end else begin
         prev_fg_in = fg;
         column_in  = col_next[COL_BITS-1:0];
         row_in     = row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_fg_ff   <= 1'b0;
         column_ff    <= '0;
         row_ff       <= '0;
         run_start_ff <= '0;
      end else if (step) begin
         prev_fg_ff   <= prev_fg_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         run_start_ff <= run_start_in;
      end
   end

endmodule

FILE: design/band_threshold_run_encoder_unit.sv
// top level of the band threshold run encoder
//
// usage:
//    req channel: one gray pixel per beat in raster order, req_frame_start
//    high on the first pixel of an image. a beat is taken when req_valid is
//    high and req_stall is low.
//    rsp channel: one beat per closed foreground run (row, first column,
//    exclusive end column). a run closes at a background pixel or at the
//    last pixel of a row; pixels that close no run give no beat.
//    csr channel: writes low_gray (0), high_gray (1), row_width (2);
//    csr_ready is always high. write only while the block is idle.
// timing:
//    a taken pixel waits in the input register and is classified there;
//    its run beat, if any, goes to the result register once that is free.
//    one pixel per cycle when rsp_stall is low; the output and the input
//    registers let a new pixel in while a run beat waits to be taken.
// reset: synchronous; clears the valid bits of both pipeline registers,
//    the scan position and the registers to low 0, high 255, width 640.
// stall: with rsp_stall high and a beat waiting, one more pixel is held in
//    the input register, then req_stall rises.
module band_threshold_run_encoder_unit
   import btre_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   // pixel input
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [PIXEL_BITS-1:0]     req_pixel,
   input  logic                      req_frame_start,
   // run output
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [RUN_POS_BITS-1:0]   rsp_run_row,
   output logic [RUN_POS_BITS-1:0]   rsp_run_begin,
   output logic [RUN_END_BITS-1:0]   rsp_run_end,
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type cfg;
   run_type run;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [PIXEL_BITS-1:0] in_pixel_ff;
   logic                  in_frame_start_ff;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RUN_POS_BITS-1:0] rsp_row_ff, rsp_begin_ff;
   logic [RUN_END_BITS-1:0] rsp_end_ff;

   logic out_free;   // result register can take a new run this cycle
   logic step;       // pixel in the input register is processed
   logic take_req;

   assign csr_ready = 1'b1;

   btre_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   btre_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .step        (step),
      .pixel       (in_pixel_ff),
      .frame_start (in_frame_start_ff),
      .run         (run)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      step      = in_valid_ff && out_free;
      // input register is free when empty or drained this cycle
      req_stall = in_valid_ff && !out_free;
      take_req  = req_valid && !req_stall;

      in_valid_in = in_valid_ff;
      if (!req_stall)
         in_valid_in = req_valid;

      rsp_valid_in = rsp_valid_ff;
      if (out_free)
         rsp_valid_in = step && run.hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_pixel_ff       <= req_pixel;
         in_frame_start_ff <= req_frame_start;
      end
      if (step && run.hit) begin
         rsp_row_ff   <= run.run_row;
         rsp_begin_ff <= run.run_begin;
         rsp_end_ff   <= run.run_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_run_row   = rsp_row_ff;
   assign rsp_run_begin = rsp_begin_ff;
   assign rsp_run_end   = rsp_end_ff;

`ifndef SYNTHESIS
   // back pressure only when both registers are occupied and the sink stalls
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("req_stall raised without a blocked result beat");

   // a pixel that cannot be processed stays in the input register
   a_pixel_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> in_valid_ff)
      else $error("pending pixel lost while the output was blocked");

   // a reported run is never empty when columns fit the output fields
   a_run_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (MAX_WIDTH <= 4096)) |->
         (rsp_end_ff > RUN_END_BITS'(rsp_begin_ff)))
      else $error("run end not beyond run begin");
`endif

endmodule
